### rtl/segment_rle_encoder_with_fallback_defines.svh
// Assertion macros shared by the run-length encoder RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef SEGMENT_RLE_ENCODER_WITH_FALLBACK_DEFINES_SVH
`define SEGMENT_RLE_ENCODER_WITH_FALLBACK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRLE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srle check failed");

// Next-cycle implication, checked outside reset.
`define SRLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srle check failed");

`endif

### rtl/srle_pkg.sv
// Shared types and constants of the segment run-length encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
package srle_pkg;

   localparam int unsigned MAX_SEGMENT         = 16384;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [16:0] MAX_SEGMENT_CMP = 17'(MAX_SEGMENT);
   localparam logic [14:0] IN_COUNT_MAX    = 15'h7FFF;
   localparam logic [15:0] OUT_COUNT_MAX   = 16'hFFFF;
   localparam logic [7:0]  RUN_LEN_FULL    = 8'hFF;

   typedef struct packed {
      logic [15:0] enc_len;
      logic        fallback;
      logic        seg_end;
      logic [7:0]  count_less_one;
      logic [7:0]  value;
   } pair_type;

   // Work for the back end from one request: a closed run and/or the final pair.
   typedef struct packed {
      logic     close_vld;
      pair_type close_pair;
      logic     final_vld;
      pair_type final_pair;
   } entry_type;

endpackage

### rtl/segment_rle_encoder_with_fallback.sv
// Top level of the segment run-length encoder with raw fallback.
// Depends on srle_pkg, srle_front, srle_queue, srle_back and the macro header.
//
// Usage:
//   The request channel (req_*) takes one captured byte per beat in req_tdata;
//   req_tlast marks the final byte of a segment. The result channel (rsp_*)
//   returns (value, count-1) pairs. rsp_tlast marks the final pair of a
//   segment; on that pair rsp_tuser is the fallback flag (discard the pairs,
//   send raw) and rsp_tdata[31:16] the encoded length in bytes. Both are zero
//   on every other pair.
//   A pair caused by an accepted request passes the queue slot and then the
//   result register before rsp_*. Intake is one request per cycle while the
//   queue is not full; the final byte of a segment that also closes a run
//   yields two pairs, sent one after the other. The front end and the result
//   register are parted by a QUEUE_DEPTH-entry queue, so a short receiver
//   stall does not stop intake; req_tready drops only once the queue is full.
//   Reset clears the open run, both segment counts, the queue and the output
//   valid, so the next byte starts a fresh segment.
`include "segment_rle_encoder_with_fallback_defines.svh"

module segment_rle_encoder_with_fallback #(
   parameter int unsigned QUEUE_DEPTH = srle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // segment_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] run_value, [15:8] run_count_less_one,
                                    // [31:16] encoded_length
   output logic        rsp_tuser,   // [0] fallback_raw
   output logic        rsp_tlast    // segment_end
);
   import srle_pkg::*;

   entry_type push_entry;
   entry_type pop_entry;
   logic      push;
   logic      q_not_full;
   logic      pop;
   logic      q_not_empty;
   pair_type  out_pair;

   // Front: classify each byte against the open run and build queue entries.
   srle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .data_byte (req_tdata),
      .seg_last  (req_tlast),
      .q_ready   (q_not_full),
      .q_push    (push),
      .q_entry   (push_entry)
   );

   // Queue: absorb output stalls and the second pair of a closing final byte.
   srle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .not_full   (q_not_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (q_not_empty)
   );

   // Back: emit one pair per cycle into the result register while the output is not stalled.
   srle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_entry   (pop_entry),
      .q_pop     (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pair  (out_pair)
   );

   assign rsp_tdata = {out_pair.enc_len, out_pair.count_less_one, out_pair.value};
   assign rsp_tuser = out_pair.fallback;
   assign rsp_tlast = out_pair.seg_end;

   // Any request that ends a segment must leave work in the queue.
   `SRLE_ASSERT_IMPL(a_last_pushes, clock, reset, req_tvalid && req_tready && req_tlast, push)

endmodule

### rtl/srle_front.sv
// Front end: accepts bytes, tracks the open run and segment counts, builds entries.
// Depends on srle_pkg and the assertion macro header.
`include "segment_rle_encoder_with_fallback_defines.svh"

module srle_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          data_byte,
   input  logic                seg_last,
   input  logic                q_ready,
   output logic                q_push,
   output srle_pkg::entry_type q_entry
);
   import srle_pkg::*;

   logic [7:0]  run_byte_ff, run_byte_in;
   logic [7:0]  run_len_ff, run_len_in;
   logic        run_open_ff, run_open_in;
   logic [14:0] in_count_ff, in_count_in;
   logic [15:0] out_count_ff, out_count_in;

   logic        accept;
   logic        extend;
   logic        close;
   logic [14:0] in_new;
   logic [16:0] out_sum;
   logic [15:0] out_new;
   logic [7:0]  cur_byte;
   logic [7:0]  cur_len;
   logic        fallback;

   assign in_ready = q_ready;
   assign accept   = in_valid && q_ready;

   always_comb begin
      in_new   = (in_count_ff == IN_COUNT_MAX) ? in_count_ff : in_count_ff + 15'd1;
      extend   = run_open_ff && (data_byte == run_byte_ff) && (run_len_ff != RUN_LEN_FULL);
      close    = run_open_ff && !extend;
      out_sum  = {1'b0, out_count_ff} + {15'd0, close, 1'b0} + {15'd0, seg_last, 1'b0};
      out_new  = out_sum[16] ? OUT_COUNT_MAX : out_sum[15:0];
      cur_byte = extend ? run_byte_ff : data_byte;
      cur_len  = extend ? run_len_ff + 8'd1 : 8'd0;
      fallback = (out_new > {1'b0, in_new}) || ({2'b0, in_new} > MAX_SEGMENT_CMP) ||
                 (in_new == IN_COUNT_MAX);

      q_entry.close_vld                 = close;
      q_entry.close_pair.value          = run_byte_ff;
      q_entry.close_pair.count_less_one = run_len_ff;
      q_entry.close_pair.seg_end        = 1'b0;
      q_entry.close_pair.fallback       = 1'b0;
      q_entry.close_pair.enc_len        = 16'd0;
      q_entry.final_vld                 = seg_last;
      q_entry.final_pair.value          = cur_byte;
      q_entry.final_pair.count_less_one = cur_len;
      q_entry.final_pair.seg_end        = 1'b1;
      q_entry.final_pair.fallback       = fallback;
      q_entry.final_pair.enc_len        = out_new;

      q_push = accept && (close || seg_last);

      run_byte_in  = run_byte_ff;
      run_len_in   = run_len_ff;
      run_open_in  = run_open_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      if (accept) begin
         if (seg_last) begin
            // segment done: drop all state for the next one
            run_byte_in  = 8'd0;
            run_len_in   = 8'd0;
            run_open_in  = 1'b0;
            in_count_in  = 15'd0;
            out_count_in = 16'd0;
         end else begin
            run_byte_in  = cur_byte;
            run_len_in   = cur_len;
            run_open_in  = 1'b1;
            in_count_in  = in_new;
            out_count_in = out_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_byte_ff  <= 8'd0;
         run_len_ff   <= 8'd0;
         run_open_ff  <= 1'b0;
         in_count_ff  <= 15'd0;
         out_count_ff <= 16'd0;
      end else begin
         run_byte_ff  <= run_byte_in;
         run_len_ff   <= run_len_in;
         run_open_ff  <= run_open_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
      end
   end

   `SRLE_ASSERT_NEXT(a_last_clears_state, clock, reset, accept && seg_last,
                     !run_open_ff && in_count_ff == 15'd0 && out_count_ff == 16'd0)
   `SRLE_ASSERT_IMPL(a_open_run_counted, clock, reset, run_open_ff, in_count_ff != 15'd0)

endmodule

### rtl/srle_queue.sv
// Short FIFO of encoder entries between the front and back ends.
// Depends on srle_pkg and the assertion macro header.
`include "segment_rle_encoder_with_fallback_defines.svh"

module srle_queue #(
   parameter int unsigned DEPTH = srle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  srle_pkg::entry_type push_entry,
   output logic                not_full,
   input  logic                pop,
   output srle_pkg::entry_type pop_entry,
   output logic                not_empty
);
   import srle_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_full  = (count_ff != FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SRLE_ASSERT_IMPL(a_no_overflow, clock, reset, push, not_full)
   `SRLE_ASSERT_IMPL(a_no_underflow, clock, reset, pop, not_empty)
   `SRLE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT)

endmodule

### rtl/srle_back.sv
// Back end: splits each entry into one or two pairs and drives the output register.
// Depends on srle_pkg and the assertion macro header.
`include "segment_rle_encoder_with_fallback_defines.svh"

module srle_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  srle_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output srle_pkg::pair_type  out_pair
);
   import srle_pkg::*;

   logic     phase_ff, phase_in;
   logic     valid_ff, valid_in;
   pair_type pair_ff;

   logic     load;
   logic     send_close;
   logic     last_piece;
   pair_type pick;

   always_comb begin
      load       = q_valid && (!valid_ff || out_ready);
      send_close = q_entry.close_vld && !phase_ff;
      last_piece = !send_close || !q_entry.final_vld;
      pick       = send_close ? q_entry.close_pair : q_entry.final_pair;
      q_pop      = load && last_piece;

      phase_in = phase_ff;
      if (load) begin
         phase_in = !last_piece;
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pair_ff <= pick;
      end
   end

   assign out_valid = valid_ff;
   assign out_pair  = pair_ff;

   `SRLE_ASSERT_IMPL(a_mid_pair_clean, clock, reset, valid_ff && !pair_ff.seg_end,
                     !pair_ff.fallback && pair_ff.enc_len == 16'd0)
   `SRLE_ASSERT_IMPL(a_phase_needs_final, clock, reset, phase_ff,
                     q_valid && q_entry.close_vld && q_entry.final_vld)

endmodule

### tb/sv/testbench.sv
// Self-checking bench for segment_rle_encoder_with_fallback: streams byte segments,
// predicts the (value, count-1) pairs and end-of-segment fields, and checks each pair.
// Depends on srle_pkg and the encoder RTL only.
module testbench;
   import srle_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 2_000_000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES    = 32;
   localparam int unsigned RANDOM_ITEMS    = 820;
   localparam int unsigned REPORT_LIMIT    = 10;

   typedef enum int unsigned {
      READY_ALWAYS,
      READY_COIN,
      READY_ONE_IN_FOUR,
      READY_MOSTLY
   } ready_mode_type;

   // Tracks the encoder state per accepted request and holds the pairs still owed.
   class rle_pair_checker;
      logic [7:0]  run_value;
      logic [7:0]  run_len_less_one;
      bit          run_open;
      logic [14:0] bytes_in;
      logic [15:0] bytes_out;
      pair_type    pending_pairs[$];
      int unsigned failures = 0;

      function new();
         restart();
      endfunction

      function void restart();
         run_value        = '0;
         run_len_less_one = '0;
         run_open         = 1'b0;
         bytes_in         = '0;
         bytes_out        = '0;
      endfunction

      function void add_pair_bytes();
         if (bytes_out >= 16'hFFFE) begin
            bytes_out = OUT_COUNT_MAX;
         end else begin
            bytes_out = bytes_out + 16'd2;
         end
      endfunction

      function void push_pair(logic seg_end, logic fallback, logic [15:0] enc_len);
         pair_type p;
         p.value          = run_value;
         p.count_less_one = run_len_less_one;
         p.seg_end        = seg_end;
         p.fallback       = fallback;
         p.enc_len        = enc_len;
         pending_pairs.push_back(p);
      endfunction

      function void note_byte(logic [7:0] data_val, logic seg_last);
         logic fallback;
         if (bytes_in != IN_COUNT_MAX) bytes_in = bytes_in + 15'd1;
         if (run_open && data_val == run_value && run_len_less_one != RUN_LEN_FULL) begin
            run_len_less_one = run_len_less_one + 8'd1;
         end else begin
            if (run_open) begin
               push_pair(1'b0, 1'b0, 16'd0);
               add_pair_bytes();
            end
            run_value        = data_val;
            run_len_less_one = '0;
            run_open         = 1'b1;
         end
         if (seg_last) begin
            add_pair_bytes();
            fallback = ({1'b0, bytes_in} < bytes_out) ||
                       ({2'b00, bytes_in} > MAX_SEGMENT_CMP) ||
                       (bytes_in == IN_COUNT_MAX);
            push_pair(1'b1, fallback, bytes_out);
            restart();
         end
      endfunction

      function void check_pair(logic [31:0] data, logic user, logic seg_end);
         pair_type want;
         if (pending_pairs.size() == 0) begin
            if (failures < REPORT_LIMIT)
               $display("unexpected pair: data %08h user %0b last %0b", data, user, seg_end);
            failures++;
            return;
         end
         want = pending_pairs.pop_front();
         if (data[7:0] !== want.value || data[15:8] !== want.count_less_one ||
             data[31:16] !== want.enc_len || user !== want.fallback ||
             seg_end !== want.seg_end) begin
            if (failures < REPORT_LIMIT)
               $display({"pair mismatch: expected value %02h count-1 %0d end %0b fb %0b",
                         " len %0d, got value %02h count-1 %0d end %0b fb %0b len %0d"},
                        want.value, want.count_less_one, want.seg_end, want.fallback,
                        want.enc_len, data[7:0], data[15:8], seg_end, user, data[31:16]);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;    // segment_last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [7:0] run_value, [15:8] run_count_less_one,
                              // [31:16] encoded_length
   logic        rsp_tuser;    // [0] fallback_raw
   logic        rsp_tlast;    // segment_end

   rle_pair_checker encoder_check = new;

   int unsigned cycle_count      = 0;
   int unsigned items_sent       = 0;
   int unsigned burst_left       = 0;
   bit          gaps_on          = 1'b1;
   bit          hold_off_request = 1'b0;

   segment_rle_encoder_with_fallback i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Check every pair taken by the receiver.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         encoder_check.check_pair(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Receiver: switch between ready patterns, and hold off for a long stretch
   // once on request so the encoder queue fills and req_tready drops.
   initial begin
      ready_mode_type mode;
      int unsigned    mode_left;
      int unsigned    phase;
      mode       = READY_ALWAYS;
      mode_left  = 0;
      phase      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         phase++;
         case (mode)
            READY_ALWAYS:      rsp_tready <= 1'b1;
            READY_COIN:        rsp_tready <= 1'($urandom_range(0, 1));
            READY_ONE_IN_FOUR: rsp_tready <= (phase % 4 == 0);
            default:           rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Drop valid and scramble the data lines.
   task automatic idle_cycles(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tlast  <= 1'($urandom);
      end
   endtask

   // Offer one request, hold it until accepted, then predict its pairs.
   task automatic send_byte(logic [7:0] data_val, logic seg_last);
      if (gaps_on) begin
         if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
         end
         burst_left--;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data_val;
      req_tlast  <= seg_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      encoder_check.note_byte(data_val, seg_last);
      items_sent++;
   endtask

   // Send a whole segment built from runs of random length up to max_run.
   task automatic send_segment(int unsigned seg_len, int unsigned max_run);
      logic [7:0]  cur;
      int unsigned run_left;
      cur      = 8'($urandom);
      run_left = $urandom_range(1, max_run);
      for (int unsigned i = 0; i < seg_len; i++) begin
         if (run_left == 0) begin
            cur      = 8'($urandom);
            run_left = $urandom_range(1, max_run);
         end
         send_byte(cur, i == seg_len - 1);
         run_left--;
      end
   endtask

   initial begin
      int unsigned random_end;
      int unsigned pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // One-byte segment: encoding is twice the input, so fall back.
      send_byte(8'h00, 1'b1);
      // Equal length (2 in, 2 out) is not a fallback.
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // Last byte closes a run and opens one: two pairs from one request.
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h7F, 1'b1);
      // Shorter encoding than input.
      send_byte(8'h01, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h01, 1'b1);
      // Every byte differs: pairs before the end carry zero end fields.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // Random segments; the receiver holds off early on while requests keep coming.
      hold_off_request = 1'b1;
      random_end = items_sent + RANDOM_ITEMS;
      while (items_sent < random_end) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            send_segment($urandom_range(1, 24), $urandom_range(1, 4));
         end else if (pick < 17) begin
            send_segment($urandom_range(25, 120), $urandom_range(1, 20));
         end else if (pick < 18) begin
            send_segment($urandom_range(250, 300), 300);
         end else begin
            // Noise: random bytes with random segment marks.
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
         end
      end
      // Close whatever segment the noise left open.
      send_byte(8'($urandom), 1'b1);

      // Long segments, sent back to back.
      gaps_on = 1'b0;
      // Exactly one full run of 256.
      for (int i = 0; i < 256; i++) send_byte(8'hC3, i == 255);
      // A full run followed by the same byte starts a new run.
      for (int i = 0; i < 258; i++) send_byte(8'h3C, i == 257);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (encoder_check.pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (encoder_check.failures == 0 && encoder_check.pending_pairs.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
